// ===== hdl/ssm_pkg.sv =====
// Package for the sorted set merge unit: beat types, codes and sizing constants.
package ssm_pkg;

  // Default sizing of the element lists.
  localparam int LIST_DEPTH_DEF  = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Depth of the command queue between front and back.
  localparam int CMD_DEPTH = 4;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_OPERATION = 1'b0;

  // Input kind codes.
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_RUN    = 2'd2;

  // Operation codes.
  localparam logic [1:0] OP_DIFF  = 2'd0;
  localparam logic [1:0] OP_INTER = 2'd1;
  localparam logic [1:0] OP_SYMD  = 2'd2;
  localparam logic [1:0] OP_UNION = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } ssm_in_t;

  typedef struct packed {
    logic [31:0] element;
    logic        valid_res;
    logic        last;
    logic        overflow;
  } ssm_out_t;

  typedef enum logic [1:0] {
    CMD_APPEND_FIRST,
    CMD_APPEND_SECOND,
    CMD_RUN
  } ssm_cmd_kind_t;

  typedef struct packed {
    ssm_cmd_kind_t kind;
    logic [31:0]   value;
  } ssm_cmd_t;

endpackage

// ===== hdl/ssm_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
module ssm_front
  import ssm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ssm_in_t  in_data,
  input  logic     fifo_full,
  output logic     push,
  output ssm_cmd_t push_cmd
);

  logic known;

  // Map the input kind onto a command; an unused kind is swallowed.
  always_comb begin
    known         = 1'b1;
    push_cmd.kind = CMD_RUN;
    push_cmd.value = in_data.value;
    case (in_data.kind)
      KIND_FIRST: begin
        push_cmd.kind = CMD_APPEND_FIRST;
      end
      KIND_SECOND: begin
        push_cmd.kind = CMD_APPEND_SECOND;
      end
      KIND_RUN: begin
        push_cmd.kind = CMD_RUN;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Stall while the queue is full, and out of reset until ready_r is set.
  logic ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= 1'b1;
    end
  end

  assign in_stall = fifo_full || !ready_r;
  assign push     = in_valid && !in_stall && known;

endmodule

// ===== hdl/ssm_cmd_fifo.sv =====
// Short command queue that decouples the front end from the merge engine.
module ssm_cmd_fifo
  import ssm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ssm_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     cmd_valid,
  output ssm_cmd_t cmd
);

  localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int NW = $clog2(CMD_DEPTH + 1);

  ssm_cmd_t        slots_r [CMD_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   fill_r, fill_nxt;
  logic            do_push, do_pop;

  assign full      = (fill_r == NW'(CMD_DEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && cmd_valid;

  // Pointer and fill updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + NW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Slot storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/ssm_back.sv =====
// Merge engine: holds both lists, performs appends and steps through a merge.
module ssm_back
  import ssm_pkg::*;
#(
  parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] operation,
  input  logic       cmd_valid,
  input  ssm_cmd_t   cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output ssm_out_t   out_data
);

  localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  logic [SW-1:0] first_mem  [LIST_DEPTH];
  logic [SW-1:0] second_mem [LIST_DEPTH];

  state_t        state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic          drop_r, drop_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [SW-1:0] pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  ssm_out_t      out_data_r, out_data_nxt;

  logic          wr_a, wr_b;
  logic [SW-1:0] a_val, b_val;
  logic          a_ok, b_ok, a_lt, b_lt;
  logic          adv_i, adv_j, emit, done;
  logic [SW-1:0] emit_val;
  logic          out_free;

  assign a_val    = first_mem[i_r[IW-1:0]];
  assign b_val    = second_mem[j_r[IW-1:0]];
  assign a_ok     = (i_r < cnt_a_r);
  assign b_ok     = (j_r < cnt_b_r);
  assign a_lt     = (a_val < b_val);
  assign b_lt     = (b_val < a_val);
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == ST_IDLE) && cmd_valid;

  // One merge step: which heads advance and whether one of them is emitted.
  always_comb begin
    adv_i    = 1'b0;
    adv_j    = 1'b0;
    emit     = 1'b0;
    emit_val = a_val;
    done     = 1'b0;
    case (operation)
      OP_DIFF: begin
        if (!a_ok) begin
          done = 1'b1;
        end else if (!b_ok || a_lt) begin
          emit  = 1'b1;
          adv_i = 1'b1;
        end else if (b_lt) begin
          adv_j = 1'b1;
        end else begin
          adv_i = 1'b1;
          adv_j = 1'b1;
        end
      end
      OP_INTER: begin
        if (!a_ok || !b_ok) begin
          done = 1'b1;
        end else if (a_lt) begin
          adv_i = 1'b1;
        end else if (b_lt) begin
          adv_j = 1'b1;
        end else begin
          emit  = 1'b1;
          adv_i = 1'b1;
          adv_j = 1'b1;
        end
      end
      default: begin
        if (!a_ok && !b_ok) begin
          done = 1'b1;
        end else if (!a_ok) begin
          emit     = 1'b1;
          emit_val = b_val;
          adv_j    = 1'b1;
        end else if (!b_ok || a_lt) begin
          emit  = 1'b1;
          adv_i = 1'b1;
        end else if (b_lt) begin
          emit     = 1'b1;
          emit_val = b_val;
          adv_j    = 1'b1;
        end else begin
          emit  = (operation == OP_UNION);
          adv_i = 1'b1;
          adv_j = 1'b1;
        end
      end
    endcase
  end

  // Sequencer: appends in idle, one merge step per cycle unless stalled.
  // The newest found element is held back so the final one can carry last.
  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    drop_nxt       = drop_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    wr_a           = 1'b0;
    wr_b           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_APPEND_FIRST: begin
              if (cnt_a_r < CW'(LIST_DEPTH)) begin
                wr_a      = 1'b1;
                cnt_a_nxt = cnt_a_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_APPEND_SECOND: begin
              if (cnt_b_r < CW'(LIST_DEPTH)) begin
                wr_b      = 1'b1;
                cnt_b_nxt = cnt_b_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_RUN: begin
              i_nxt          = '0;
              j_nxt          = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = ST_RUN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (out_free) begin
          if (done) begin
            // Final beat: the held element, or an empty marker.
            out_valid_nxt          = 1'b1;
            out_data_nxt.element   = pend_valid_r ? 32'(pend_r) : '0;
            out_data_nxt.valid_res = pend_valid_r;
            out_data_nxt.last      = 1'b1;
            out_data_nxt.overflow  = drop_r;
            pend_valid_nxt         = 1'b0;
            cnt_a_nxt              = '0;
            cnt_b_nxt              = '0;
            drop_nxt               = 1'b0;
            state_nxt              = ST_IDLE;
          end else begin
            if (adv_i) begin
              i_nxt = i_r + CW'(1);
            end
            if (adv_j) begin
              j_nxt = j_r + CW'(1);
            end
            if (emit) begin
              if (pend_valid_r) begin
                out_valid_nxt          = 1'b1;
                out_data_nxt.element   = 32'(pend_r);
                out_data_nxt.valid_res = 1'b1;
                out_data_nxt.last      = 1'b0;
                out_data_nxt.overflow  = drop_r;
              end
              pend_valid_nxt = 1'b1;
              pend_nxt       = emit_val;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      i_r          <= '0;
      j_r          <= '0;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      drop_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      drop_r       <= drop_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  // List storage; entries at or above the counts never reach the output.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      first_mem[cnt_a_r[IW-1:0]] <= cmd.value[SW-1:0];
    end
    if (wr_b) begin
      second_mem[cnt_b_r[IW-1:0]] <= cmd.value[SW-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/sorted_set_merge_operations_top.sv =====
// Sorted set merge unit: difference, intersection, symmetric difference or union of two lists.
// After reset the input waits on ready_r, then takes one beat per cycle unless the fifo fills.
// A run holds the engine while it takes the command, performs merge steps (at most both
// counts summed) and registers the final beat, longer under output stalls. A four-entry
// queue buffers beats.
// Synchronous active-low reset empties both lists, clears overflow and selects difference.
module sorted_set_merge_operations_top
  import ssm_pkg::*;
#(
  parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ssm_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ssm_out_t              out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [1:0] operation_r, operation_nxt;
  logic       reg_sel;
  logic       push, fifo_full, pop, cmd_valid;
  ssm_cmd_t   push_cmd, cmd;

  // Configuration register: one word per register index.
  assign reg_sel    = (cfg_paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W - 2)'(REG_OPERATION));
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? CFG_DATA_W'(operation_r) : '0;

  always_comb begin
    operation_nxt = operation_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      operation_nxt = cfg_pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operation_r <= OP_DIFF;
    end else begin
      operation_r <= operation_nxt;
    end
  end

  ssm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  ssm_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  ssm_back #(
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .operation (operation_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
